[hdl/sound_cart_ram_bank_mapper_core_macros.svh]
// assertion macros shared by the bank mapper checker
`ifndef SOUND_CART_RAM_BANK_MAPPER_CORE_MACROS_SVH
`define SOUND_CART_RAM_BANK_MAPPER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SCBM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bank mapper check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SCBM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bank mapper check failed");

`endif

[hdl/scbm_pkg.sv]
// shared types and constants of the sound cartridge bank mapper
package scbm_pkg;

    // number of populated ram banks in the selected group (1..8)
    localparam int RAM_BANKS = 8;

    // item widths
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    // sound operation codes
    typedef enum logic [2:0] {
        OP_NONE        = 3'd0,
        OP_COMPAT_WAVE = 3'd1,
        OP_PLUS_WAVE   = 3'd2,
        OP_FREQ        = 3'd3,
        OP_VOLUME      = 3'd4,
        OP_KEY         = 3'd5,
        OP_TEST        = 3'd6
    } sound_op_t;

    // address decode constants
    localparam logic [1:0] SUB_SELECT    = 2'b10;
    localparam logic [1:0] SUB_SOUND     = 2'b11;
    localparam logic [4:0] COMPAT_WIN_HI = 5'b10011;
    localparam logic [4:0] PLUS_WIN_HI   = 5'b10111;
    localparam logic [1:0] SLOT_COMPAT   = 2'd2;
    localparam logic [1:0] SLOT_PLUS     = 2'd3;

endpackage

[hdl/sound_cart_ram_bank_mapper_core.sv]
// sound cartridge bank mapper: page to bank mapping and sound window decode
// One bus access enters per cycle on the s_ side and its single result item
// leaves on the m_ side after passing the input register, where the decode
// logic also works out the bank select, ram write enable and sound window
// flag updates, and then the result register. A stalled
// result side holds both stages; while the result side keeps taking items a
// new item is accepted every cycle. The ram bank group register is
// written through cfg_we/cfg_wdata and must only change while no item is in
// flight. RAM contents and the sound chip live outside this block.
module sound_cart_ram_bank_mapper_core
(
    input  logic        clk,
    input  logic        rst_n,
    // ram bank group register
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    // access side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [scbm_pkg::IN_DATA_W-1:0]  s_tdata,  // address[15:0], write_data[23:16]
    input  logic        s_tuser,   // action (0 read, 1 write)
    // result side
    output logic        m_tvalid,
    input  logic        m_tready,
    // mem_access[0], mem_write[1], mem_address[17:2], sound_op[20:18],
    // sound_index[28:21], sound_write[29], open_bus[30], data_out[38:31]
    output logic [scbm_pkg::OUT_DATA_W-1:0] m_tdata
);

    // configuration and mapper state
    logic       ram_bank_group_reg;
    logic [7:0] bank_select_reg [4];
    logic [7:0] bank_select_next [4];
    logic [3:0] ram_write_enable_reg, ram_write_enable_next;
    logic       compat_sound_on_reg, compat_sound_on_next;
    logic       plus_sound_on_reg, plus_sound_on_next;

    // input register
    logic        in_valid_reg;
    logic        in_action_reg;
    logic [15:0] in_address_reg;
    logic [7:0]  in_wdata_reg;

    // result register
    logic                             out_valid_reg;
    logic [scbm_pkg::OUT_DATA_W-1:0]  out_data_reg, out_data_next;

    logic advance;

    // decode temporaries
    logic [2:0]          page;
    logic [1:0]          slot;
    logic [7:0]          low;
    logic [1:0]          sub;
    logic [3:0]          bank;
    logic [4:0]          bank_base;
    logic [4:0]          bank_ext;
    logic                bank_pop;
    logic                in_compat_win;
    logic                in_plus_win;
    logic                in_rw_pages;
    logic                mode_addr;
    logic [3:0]          reg_nib;
    scbm_pkg::sound_op_t reg_op;
    logic [7:0]          reg_idx;

    logic                mem_access;
    logic                mem_write;
    logic [15:0]         mem_address;
    scbm_pkg::sound_op_t sound_op;
    logic [7:0]          sound_index;
    logic                sound_write;
    logic                open_bus;
    logic [7:0]          data_out;
    logic                all_en;

    // pipeline handshake
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // address fields of the item in the decode stage
    assign page          = in_address_reg[15:13];
    assign slot          = page[1:0] + 2'd2;
    assign low           = in_address_reg[7:0];
    assign sub           = in_address_reg[12:11];
    assign bank          = bank_select_reg[slot][3:0];
    assign bank_base     = {1'b0, ram_bank_group_reg, 3'b000};
    assign bank_ext      = {1'b0, bank};
    assign bank_pop      = (bank_ext >= bank_base)
                           && ((bank_ext - bank_base) < 5'(scbm_pkg::RAM_BANKS));
    assign in_compat_win = (in_address_reg[15:11] == scbm_pkg::COMPAT_WIN_HI)
                           && (in_address_reg[10:5] != 6'h3f);
    assign in_plus_win   = (in_address_reg[15:11] == scbm_pkg::PLUS_WIN_HI)
                           && (in_address_reg[10:5] != 6'h3f);
    assign in_rw_pages   = (page[2:1] == 2'b01) || (page[2:1] == 2'b10);
    assign mode_addr     = (in_address_reg[10:1] == 10'h3ff);

    // frequency / volume / key decode from the low nibble
    assign reg_nib = low[3:0];
    always_comb
    begin
        if (reg_nib < 4'd10)
        begin
            reg_op  = scbm_pkg::OP_FREQ;
            reg_idx = {4'd0, reg_nib};
        end
        else if (reg_nib < 4'd15)
        begin
            reg_op  = scbm_pkg::OP_VOLUME;
            reg_idx = {4'd0, reg_nib - 4'd10};
        end
        else
        begin
            reg_op  = scbm_pkg::OP_KEY;
            reg_idx = 8'd0;
        end
    end

    // access decode and state update
    always_comb
    begin
        mem_access            = 1'b0;
        mem_write             = 1'b0;
        mem_address           = 16'd0;
        sound_op              = scbm_pkg::OP_NONE;
        sound_index           = 8'd0;
        sound_write           = 1'b0;
        open_bus              = 1'b0;
        data_out              = 8'd0;
        all_en                = in_wdata_reg[4];
        bank_select_next      = bank_select_reg;
        ram_write_enable_next = ram_write_enable_reg;
        compat_sound_on_next  = compat_sound_on_reg;
        plus_sound_on_next    = plus_sound_on_reg;

        if (!in_action_reg)
        begin
            // read access
            if (compat_sound_on_reg && in_compat_win)
            begin
                if (low < 8'h80)
                begin
                    sound_op    = scbm_pkg::OP_COMPAT_WAVE;
                    sound_index = low;
                end
                else if (low < 8'ha0)
                    open_bus = 1'b1;
                else if (low < 8'hc0)
                begin
                    sound_op    = scbm_pkg::OP_COMPAT_WAVE;
                    sound_index = low & 8'h9f;
                end
                else if (low < 8'he0)
                    sound_op = scbm_pkg::OP_TEST;
                else
                    open_bus = 1'b1;
            end
            else if (plus_sound_on_reg && in_plus_win)
            begin
                if (low < 8'ha0)
                begin
                    sound_op    = scbm_pkg::OP_PLUS_WAVE;
                    sound_index = low;
                end
                else if (low >= 8'hc0 && low < 8'he0)
                    sound_op = scbm_pkg::OP_TEST;
                else
                    open_bus = 1'b1;
            end
            else if (bank_pop)
            begin
                mem_access  = 1'b1;
                mem_address = {bank[2:0], in_address_reg[12:0]};
            end
            else
                open_bus = 1'b1;
        end
        else
        begin
            data_out = in_wdata_reg;
            if (in_rw_pages)
            begin
                // ram write uses the bank before any select update
                if (ram_write_enable_reg[slot] && bank_pop)
                begin
                    mem_access  = 1'b1;
                    mem_write   = 1'b1;
                    mem_address = {bank[2:0], in_address_reg[12:0]};
                end
                if (sub == scbm_pkg::SUB_SELECT)
                begin
                    bank_select_next[slot] = in_wdata_reg;
                    if (slot == scbm_pkg::SLOT_COMPAT)
                        compat_sound_on_next = (in_wdata_reg[5:0] == 6'h3f);
                end
                else if (sub == scbm_pkg::SUB_SOUND && slot == scbm_pkg::SLOT_COMPAT)
                begin
                    if (compat_sound_on_reg)
                    begin
                        if (low < 8'h80)
                        begin
                            sound_op    = scbm_pkg::OP_COMPAT_WAVE;
                            sound_index = low;
                        end
                        else if (low < 8'ha0)
                        begin
                            sound_op    = reg_op;
                            sound_index = reg_idx;
                        end
                        else if (low >= 8'he0)
                            sound_op = scbm_pkg::OP_TEST;
                    end
                end
                else if (sub == scbm_pkg::SUB_SOUND && slot == scbm_pkg::SLOT_PLUS)
                begin
                    if (mode_addr)
                    begin
                        // mode register
                        ram_write_enable_next = {all_en,
                            all_en || (in_wdata_reg[2] && in_wdata_reg[5]),
                            all_en || in_wdata_reg[1],
                            all_en || in_wdata_reg[0]};
                        compat_sound_on_next =
                            (bank_select_reg[scbm_pkg::SLOT_COMPAT][5:0] == 6'h3f)
                            && !in_wdata_reg[5];
                        plus_sound_on_next =
                            bank_select_reg[scbm_pkg::SLOT_PLUS][7] && in_wdata_reg[5];
                    end
                    else if (plus_sound_on_reg)
                    begin
                        if (low < 8'ha0)
                        begin
                            sound_op    = scbm_pkg::OP_PLUS_WAVE;
                            sound_index = low;
                        end
                        else if (low < 8'hc0)
                        begin
                            sound_op    = reg_op;
                            sound_index = reg_idx;
                        end
                        else if (low < 8'he0)
                            sound_op = scbm_pkg::OP_TEST;
                    end
                end
                sound_write = (sound_op != scbm_pkg::OP_NONE);
            end
        end

        out_data_next = {1'b0, data_out, open_bus, sound_write, sound_index,
                         sound_op, mem_address, mem_write, mem_access};
    end

    // control state and mapper registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_bank_group_reg   <= 1'b0;
            bank_select_reg[0]   <= 8'd0;
            bank_select_reg[1]   <= 8'd1;
            bank_select_reg[2]   <= 8'd2;
            bank_select_reg[3]   <= 8'd3;
            ram_write_enable_reg <= 4'd0;
            compat_sound_on_reg  <= 1'b0;
            plus_sound_on_reg    <= 1'b0;
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                ram_bank_group_reg <= cfg_wdata;
            if (advance)
            begin
                bank_select_reg      <= bank_select_next;
                ram_write_enable_reg <= ram_write_enable_next;
                compat_sound_on_reg  <= compat_sound_on_next;
                plus_sound_on_reg    <= plus_sound_on_next;
            end
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_action_reg  <= s_tuser;
            in_address_reg <= s_tdata[15:0];
            in_wdata_reg   <= s_tdata[23:16];
        end
        if (advance)
            out_data_reg <= out_data_next;
    end

endmodule

[hdl/scbm_checker.sv]
// port-level checker for the sound cartridge bank mapper, with its bind
`include "sound_cart_ram_bank_mapper_core_macros.svh"

module scbm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [scbm_pkg::OUT_DATA_W-1:0] m_tdata
);

    // a stalled result holds still
    `SCBM_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // a ram write is always a ram access
    `SCBM_ASSERT_IMP(a_wr_needs_acc, m_tvalid && m_tdata[1], m_tdata[0])
    // a floating read touches neither ram nor the sound chip
    `SCBM_ASSERT_IMP(a_open_alone, m_tvalid && m_tdata[30],
        !m_tdata[0] && (m_tdata[20:18] == scbm_pkg::OP_NONE))
    // no ram access means a zero ram address
    `SCBM_ASSERT_IMP(a_addr_zero, m_tvalid && !m_tdata[0], m_tdata[17:2] == 16'd0)
    // with no result waiting the access side is ready
    `SCBM_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready)

endmodule

bind sound_cart_ram_bank_mapper_core scbm_checker u_scbm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[sim/tb_top.sv]
// testbench of the sound cartridge bank mapper: predicted result items checked by field
module tb_top;

    // access kinds on s_tuser
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // result item, laid out as on m_tdata[38:0]
    typedef struct packed {
        logic [7:0]          data_out;
        logic                open_bus;
        logic                sound_write;
        logic [7:0]          sound_index;
        scbm_pkg::sound_op_t sound_op;
        logic [15:0]         mem_address;
        logic                mem_write;
        logic                mem_access;
    } access_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // address[15:0], write_data[23:16]
    logic        s_tuser   = 1'b0; // action
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;          // mem_access, mem_write, mem_address, sound_op,
                                   // sound_index, sound_write, open_bus, data_out

    // mapper state as the predictor sees it
    logic [7:0]  bank_sel [4];
    logic [3:0]  ram_we;
    logic        compat_on;
    logic        plus_on;
    logic        ram_group;

    access_result_t mapped_q [$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        m_stall       = 1'b0;
    int          fail_count    = 0;
    int          shown_count   = 0;

    sound_cart_ram_bank_mapper_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // bank number inside the populated group
    function automatic logic bank_in_group(input logic [3:0] bank);
        int base;
        base = ram_group ? 8 : 0;
        return (int'(bank) >= base) && (int'(bank) - base < scbm_pkg::RAM_BANKS);
    endfunction

    // frequency, volume or key on/off from the low nibble
    function automatic void decode_reg(input logic [7:0] low,
                                       output scbm_pkg::sound_op_t op,
                                       output logic [7:0] idx);
        logic [3:0] r;
        r = low[3:0];
        if (r < 4'd10)
        begin
            op  = scbm_pkg::OP_FREQ;
            idx = {4'd0, r};
        end
        else if (r < 4'd15)
        begin
            op  = scbm_pkg::OP_VOLUME;
            idx = {4'd0, r - 4'd10};
        end
        else
        begin
            op  = scbm_pkg::OP_KEY;
            idx = 8'd0;
        end
    endfunction

    // result of one bus access, updating the mapper state
    task automatic map_access(input logic wr, input logic [15:0] addr,
                              input logic [7:0] wdata, output access_result_t res);
        logic [2:0] page;
        logic [1:0] slot;
        logic [1:0] sel_idx;
        logic [7:0] low;
        logic [3:0] bank;
        res     = '0;
        page    = addr[15:13];
        low     = addr[7:0];
        sel_idx = page[1:0] + 2'd2;
        slot    = page[1:0] - 2'd2;
        bank    = bank_sel[sel_idx][3:0];
        if (wr == ACT_READ)
        begin
            if (compat_on && addr >= 16'h9800 && addr < 16'h9fe0)
            begin
                if (low < 8'h80)
                begin
                    res.sound_op    = scbm_pkg::OP_COMPAT_WAVE;
                    res.sound_index = low;
                end
                else if (low < 8'ha0)
                    res.open_bus = 1'b1;
                else if (low < 8'hc0)
                begin
                    res.sound_op    = scbm_pkg::OP_COMPAT_WAVE;
                    res.sound_index = low & 8'h9f;
                end
                else if (low < 8'he0)
                    res.sound_op = scbm_pkg::OP_TEST;
                else
                    res.open_bus = 1'b1;
            end
            else if (plus_on && addr >= 16'hb800 && addr < 16'hbfe0)
            begin
                if (low < 8'ha0)
                begin
                    res.sound_op    = scbm_pkg::OP_PLUS_WAVE;
                    res.sound_index = low;
                end
                else if (low >= 8'hc0 && low < 8'he0)
                    res.sound_op = scbm_pkg::OP_TEST;
                else
                    res.open_bus = 1'b1;
            end
            else if (bank_in_group(bank))
            begin
                res.mem_access  = 1'b1;
                res.mem_address = {bank[2:0], addr[12:0]};
            end
            else
                res.open_bus = 1'b1;
        end
        else if (page >= 3'd2 && page <= 3'd5)
        begin
            // ram write uses the bank from before any select update
            if (ram_we[slot] && bank_in_group(bank))
            begin
                res.mem_access  = 1'b1;
                res.mem_write   = 1'b1;
                res.mem_address = {bank[2:0], addr[12:0]};
            end
            if (addr[12:11] == scbm_pkg::SUB_SELECT)
            begin
                bank_sel[slot] = wdata;
                if (slot == scbm_pkg::SLOT_COMPAT)
                    compat_on = (wdata[5:0] == 6'h3f);
            end
            else if (addr[12:11] == scbm_pkg::SUB_SOUND && slot == scbm_pkg::SLOT_COMPAT)
            begin
                if (compat_on)
                begin
                    if (low < 8'h80)
                    begin
                        res.sound_op    = scbm_pkg::OP_COMPAT_WAVE;
                        res.sound_index = low;
                    end
                    else if (low < 8'ha0)
                        decode_reg(low, res.sound_op, res.sound_index);
                    else if (low >= 8'he0)
                        res.sound_op = scbm_pkg::OP_TEST;
                end
            end
            else if (addr[12:11] == scbm_pkg::SUB_SOUND && slot == scbm_pkg::SLOT_PLUS)
            begin
                if (addr[10:1] == 10'h3ff)
                begin
                    // mode register
                    ram_we[0] = wdata[4] | wdata[0];
                    ram_we[1] = wdata[4] | wdata[1];
                    ram_we[2] = wdata[4] | (wdata[2] & wdata[5]);
                    ram_we[3] = wdata[4];
                    compat_on = (bank_sel[scbm_pkg::SLOT_COMPAT][5:0] == 6'h3f)
                                && !wdata[5];
                    plus_on   = bank_sel[scbm_pkg::SLOT_PLUS][7] && wdata[5];
                end
                else if (plus_on)
                begin
                    if (low < 8'ha0)
                    begin
                        res.sound_op    = scbm_pkg::OP_PLUS_WAVE;
                        res.sound_index = low;
                    end
                    else if (low < 8'hc0)
                        decode_reg(low, res.sound_op, res.sound_index);
                    else if (low < 8'he0)
                        res.sound_op = scbm_pkg::OP_TEST;
                end
            end
            res.sound_write = (res.sound_op != scbm_pkg::OP_NONE);
        end
        res.data_out = (wr == ACT_WRITE) ? wdata : 8'd0;
    endtask

    // offer one item and record its expected result once taken
    task automatic issue_access(input logic wr, input logic [15:0] addr,
                                input logic [7:0] wdata);
        access_result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= wr;
        s_tdata  <= {wdata, addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        map_access(wr, addr, wdata, res);
        mapped_q.push_back(res);
    endtask

    // stop offering and let every pending result come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (mapped_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_bank_group(input logic grp);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= grp;
        @(posedge clk);
        cfg_we    <= 1'b0;
        ram_group = grp;
    endtask

    // random access, mostly aimed at select, mode and sound window decode
    function automatic void pick_access(output logic wr, output logic [15:0] addr,
                                        output logic [7:0] wdata);
        int unsigned kind;
        kind  = $urandom_range(99);
        wr    = 1'($urandom_range(1));
        addr  = 16'($urandom);
        wdata = 8'($urandom);
        if (kind < 15)
        begin
            // bank select write, often opening a window
            wr   = ACT_WRITE;
            addr = {3'($urandom_range(5, 2)), scbm_pkg::SUB_SELECT, addr[10:0]};
            if ($urandom_range(1))
                wdata[5:0] = 6'h3f;
            if ($urandom_range(1))
                wdata[7] = 1'b1;
        end
        else if (kind < 25)
        begin
            wr   = ACT_WRITE;
            addr = {3'b101, scbm_pkg::SUB_SOUND, 10'h3ff, addr[0]};
        end
        else if (kind < 50)
            addr = {3'b100, scbm_pkg::SUB_SOUND, addr[10:0]};
        else if (kind < 70)
            addr = {3'b101, scbm_pkg::SUB_SOUND, addr[10:0]};
    endfunction

    task automatic apply_reset();
        for (int i = 0; i < 4; i++)
            bank_sel[i] = 8'(i);
        ram_we    = 4'd0;
        compat_on = 1'b0;
        plus_on   = 1'b0;
        ram_group = 1'b0;
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // ram reads at both address extremes
        issue_access(ACT_READ, 16'h0000, 8'h00);
        issue_access(ACT_READ, 16'hffff, 8'h00);
        // all ram write enables on
        issue_access(ACT_WRITE, 16'hbffe, 8'h10);
        // select 0 to an unpopulated bank, ram written with the old bank
        issue_access(ACT_WRITE, 16'h5000, 8'h0c);
        issue_access(ACT_READ, 16'h4000, 8'h00);
        issue_access(ACT_WRITE, 16'h4001, 8'ha5);
        // select 2 opens the compat window
        issue_access(ACT_WRITE, 16'h9000, 8'h3f);
        issue_access(ACT_READ, 16'h9800, 8'h00);
        issue_access(ACT_READ, 16'h9880, 8'h00);
        issue_access(ACT_READ, 16'h98a5, 8'h00);
        issue_access(ACT_READ, 16'h98c0, 8'h00);
        issue_access(ACT_READ, 16'h98e0, 8'h00);
        issue_access(ACT_READ, 16'h9fe0, 8'h00);
        issue_access(ACT_WRITE, 16'h987f, 8'hff);
        issue_access(ACT_WRITE, 16'h9889, 8'h01);
        issue_access(ACT_WRITE, 16'h988a, 8'h80);
        issue_access(ACT_WRITE, 16'h988f, 8'h1f);
        issue_access(ACT_WRITE, 16'h98a0, 8'h55);
        issue_access(ACT_WRITE, 16'h98e0, 8'haa);
        // plus window through select 3 and the mode register
        issue_access(ACT_WRITE, 16'hb000, 8'h80);
        issue_access(ACT_WRITE, 16'hbfff, 8'h20);
        // both windows on
        issue_access(ACT_WRITE, 16'h9000, 8'hff);
        issue_access(ACT_READ, 16'h9810, 8'h00);
        issue_access(ACT_READ, 16'hb89f, 8'h00);
        issue_access(ACT_READ, 16'hb8a0, 8'h00);
        issue_access(ACT_WRITE, 16'hb8a3, 8'h33);
        issue_access(ACT_WRITE, 16'hb8c5, 8'h44);
        issue_access(ACT_WRITE, 16'hb8e0, 8'h66);
        wait_idle();
    endtask

    task automatic test_random(input int count, input int unsigned sidle,
                               input int unsigned ridle);
        logic        wr;
        logic [15:0] addr;
        logic [7:0]  wdata;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        repeat (count)
        begin
            pick_access(wr, addr, wdata);
            issue_access(wr, addr, wdata);
        end
        wait_idle();
    endtask

    // result side held off while items keep coming, filling the pipeline
    task automatic test_backpressure();
        logic        wr;
        logic [15:0] addr;
        logic [7:0]  wdata;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                @(negedge clk);
                m_stall = 1'b1;
                repeat (80) @(negedge clk);
                m_stall = 1'b0;
            end
            repeat (60)
            begin
                pick_access(wr, addr, wdata);
                issue_access(wr, addr, wdata);
            end
        join
        wait_idle();
    endtask

    // result side ready
    always @(posedge clk)
    begin
        if (!rst_n || m_stall)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each result item with the oldest expected one
    always @(posedge clk)
    begin
        access_result_t want;
        access_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = access_result_t'(m_tdata[38:0]);
            if (mapped_q.size() == 0)
            begin
                fail_count++;
                if (shown_count < 10)
                begin
                    shown_count++;
                    $display("unexpected result item: tdata %h", m_tdata);
                end
            end
            else
            begin
                want = mapped_q.pop_front();
                if (got.mem_access !== want.mem_access || got.mem_write !== want.mem_write
                    || got.mem_address !== want.mem_address || got.sound_op !== want.sound_op
                    || got.sound_index !== want.sound_index
                    || got.sound_write !== want.sound_write || got.open_bus !== want.open_bus
                    || got.data_out !== want.data_out)
                begin
                    fail_count++;
                    if (shown_count < 10)
                    begin
                        shown_count++;
                        $display({"mismatch: expected acc %0d wr %0d addr %h op %0d",
                                  " idx %h swr %0d open %0d data %h"},
                                 want.mem_access, want.mem_write, want.mem_address,
                                 want.sound_op, want.sound_index, want.sound_write,
                                 want.open_bus, want.data_out);
                        $display({"          actual   acc %0d wr %0d addr %h op %0d",
                                  " idx %h swr %0d open %0d data %h"},
                                 got.mem_access, got.mem_write, got.mem_address,
                                 got.sound_op, got.sound_index, got.sound_write,
                                 got.open_bus, got.data_out);
                    end
                end
            end
        end
    end

    initial
    begin
        apply_reset();
        write_bank_group(1'b0);
        test_directed();
        write_bank_group(1'b1);
        test_random(700, 11, 47);
        write_bank_group(1'b0);
        test_random(700, 47, 11);
        write_bank_group(1'b1);
        test_random(600, 0, 0);
        write_bank_group(1'b0);
        test_backpressure();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && mapped_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // run time limit
    initial
    begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule
